@@ rtl/core/aesenc_pkg.sv @@
// ----------------------------------------------------------------------------
// aesenc_pkg
// Shared types, constants and round functions for the AES-128 encrypt pipeline.
// ----------------------------------------------------------------------------
package aesenc_pkg;

    localparam int NUM_KEYS    = 11;
    localparam int FULL_ROUNDS = 9;
    localparam int BLK_W       = 128;
    localparam int IDX_W       = 4;

    typedef logic [BLK_W-1:0] block_t;
    typedef logic [7:0]       byte_t;

    typedef enum logic { OP_LOAD_KEY = 1'b0, OP_ENCRYPT = 1'b1 } op_t;

    localparam byte_t SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // byte 0 sits in the top bits
    function automatic byte_t get_byte(block_t b, int i);
        return b[BLK_W-1-8*i -: 8];
    endfunction

    function automatic byte_t xtime(byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic block_t sub_shift(block_t b);
        block_t t;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[BLK_W-1-8*(4*c+r) -: 8] = SBOX[get_byte(b, 4*((c+r)%4)+r)];
            end
        end
        return t;
    endfunction

    function automatic block_t mix_columns(block_t b);
        block_t t;
        byte_t  a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++)
        begin
            a0  = get_byte(b, 4*c);
            a1  = get_byte(b, 4*c+1);
            a2  = get_byte(b, 4*c+2);
            a3  = get_byte(b, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[BLK_W-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[BLK_W-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[BLK_W-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[BLK_W-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

endpackage

@@ rtl/core/aes128_encrypt_block_unit.sv @@
// An accepted encrypt word passes through the round registers in order to the ciphertext on m_tdata.
// Throughput: one block per cycle while m_tready does not stall the output, one register stage per AES round.
// A key load is taken only while no block is in flight, so every block sees one key set.
// Reset clears all stage valid bits; the key store is undefined until loaded.
// ----------------------------------------------------------------------------
// aes128_encrypt_block_unit
// AES-128 encryption pipeline with an externally loaded round key store.
// ----------------------------------------------------------------------------
module aes128_encrypt_block_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // round_index[3:0], word_hi[67:4], word_lo[131:68], zero pad
    input  logic [0:0]   s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // cipher_hi[63:0], cipher_lo[127:64]
);
    import aesenc_pkg::*;

    block_t               key_reg [NUM_KEYS];
    logic                 vld [FULL_ROUNDS+2];
    block_t               st  [FULL_ROUNDS+2];
    logic [FULL_ROUNDS:0] busy;
    logic                 en;
    logic                 acc;
    logic [IDX_W-1:0]     idx;
    block_t               blk_in;

    assign idx    = s_tdata[3:0];
    assign blk_in = {s_tdata[67:4], s_tdata[131:68]};
    assign en     = !m_tvalid || m_tready;

    always_comb
    begin
        for (int i = 0; i <= FULL_ROUNDS; i++)
            busy[i] = vld[i+1];
    end

    assign s_tready = en && (s_tuser[0] == OP_ENCRYPT || busy == '0);
    assign acc      = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (acc && s_tuser[0] == OP_LOAD_KEY && idx < IDX_W'(NUM_KEYS))
            key_reg[idx] <= blk_in;
    end

    assign vld[0] = acc && s_tuser[0] == OP_ENCRYPT;
    assign st[0]  = blk_in;

    genvar g;
    generate
        for (g = 0; g <= FULL_ROUNDS; g++)
        begin : g_rnd
            aesenc_round #(.FINAL(g == FULL_ROUNDS)) u_rnd (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_vld    (vld[g]),
                .in_state  (st[g]),
                .key_a     (key_reg[g]),
                .key_b     (key_reg[NUM_KEYS-1]),
                .out_vld   (vld[g+1]),
                .out_state (st[g+1])
            );
        end
    endgenerate

    assign m_tvalid = vld[FULL_ROUNDS+1];
    assign m_tdata  = {st[FULL_ROUNDS+1][63:0], st[FULL_ROUNDS+1][127:64]};
endmodule

@@ rtl/core/aesenc_round.sv @@
// ----------------------------------------------------------------------------
// aesenc_round
// One registered cipher round; the final round skips MixColumns and adds key_b.
// ----------------------------------------------------------------------------
module aesenc_round #(
    parameter bit FINAL = 1'b0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  aesenc_pkg::block_t  in_state,
    input  aesenc_pkg::block_t  key_a,
    input  aesenc_pkg::block_t  key_b,
    output logic                out_vld,
    output aesenc_pkg::block_t  out_state
);
    import aesenc_pkg::*;

    logic   vld_reg;
    block_t state_reg;
    block_t ss;
    block_t state_next;

    assign ss = sub_shift(in_state ^ key_a);

    always_comb
    begin
        if (FINAL)
            state_next = ss ^ key_b;
        else
            state_next = mix_columns(ss);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            state_reg <= state_next;
    end

    assign out_vld   = vld_reg;
    assign out_state = state_reg;
endmodule

@@ rtl/core/aesenc_checker.sv @@
// ----------------------------------------------------------------------------
// aesenc_checker
// Port-level checks for the AES-128 encrypt pipeline.
// ----------------------------------------------------------------------------
module aesenc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [0:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser[0] |=> !m_tvalid)
        else $error("key load taken with blocks in flight");

    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline stalled");

    a_reset: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid after reset");
endmodule

bind aes128_encrypt_block_unit aesenc_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/aes128_encrypt_checker.sv @@
// ----------------------------------------------------------------------------
// aes128_encrypt_checker
// Watches both stream channels of the AES-128 encrypt unit, keeps its own copy
// of the round key store, computes the ciphertext of each accepted block and
// compares it with the words leaving the unit in order.
// ----------------------------------------------------------------------------
module aes128_encrypt_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [135:0] s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    output int           errors,
    output int           pending,
    output int           blocks_seen,
    output int           loads_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import aesenc_pkg::*;

    logic [127:0] key_slot [NUM_KEYS];
    logic [127:0] cipher_q [$];

    function automatic logic [7:0] gmul2(logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] encrypt_block(logic [127:0] pt);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, x;
        logic [127:0] k, res;
        for (int i = 0; i < 16; i++)
            s[i] = pt[127-8*i -: 8];
        for (int rnd = 0; rnd < NUM_KEYS - 1; rnd++)
        begin
            k = key_slot[rnd];
            for (int i = 0; i < 16; i++)
                s[i] = s[i] ^ k[127-8*i -: 8];
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[4*c+r] = SBOX[s[4*((c+r)%4)+r]];
            s = t;
            if (rnd < FULL_ROUNDS)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                    x = a0 ^ a1 ^ a2 ^ a3;
                    s[4*c]   = a0 ^ x ^ gmul2(a0 ^ a1);
                    s[4*c+1] = a1 ^ x ^ gmul2(a1 ^ a2);
                    s[4*c+2] = a2 ^ x ^ gmul2(a2 ^ a3);
                    s[4*c+3] = a3 ^ x ^ gmul2(a3 ^ a0);
                end
            end
        end
        k = key_slot[NUM_KEYS-1];
        for (int i = 0; i < 16; i++)
            res[127-8*i -: 8] = s[i] ^ k[127-8*i -: 8];
        return res;
    endfunction

    assign pending = cipher_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [3:0]   idx;
        logic [127:0] blk;
        logic [127:0] want;
        if (!rst_n)
        begin
            errors      <= 0;
            blocks_seen <= 0;
            loads_seen  <= 0;
            cipher_q.delete();
            for (int i = 0; i < NUM_KEYS; i++)
                key_slot[i] = '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                idx = s_tdata[3:0];
                // word_lo occupies the lower half of the block
                blk = {s_tdata[67:4], s_tdata[131:68]};
                if (op_t'(s_tuser[0]) == OP_LOAD_KEY)
                begin
                    loads_seen <= loads_seen + 1;
                    if (idx < NUM_KEYS)
                        key_slot[idx] = blk;
                end
                else
                begin
                    blocks_seen <= blocks_seen + 1;
                    cipher_q.push_back(encrypt_block(blk));
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (cipher_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected ciphertext word %h", m_tdata);
                    errors <= errors + 1;
                end
                else
                begin
                    want = cipher_q.pop_front();
                    if ({m_tdata[63:0], m_tdata[127:64]} !== want)
                    begin
                        if (errors < 10)
                            $display("ciphertext: expected %h actual %h", want,
                                     {m_tdata[63:0], m_tdata[127:64]});
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

@@ tb/tb_aes128_encrypt_block_unit.sv @@
// ----------------------------------------------------------------------------
// tb_aes128_encrypt_block_unit
// Loads round key sets (FIPS-197 example keys and random ones), encrypts
// directed and random blocks under random stalls on both sides; the checker
// compares every ciphertext word.
// ----------------------------------------------------------------------------
module tb_aes128_encrypt_block_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import aesenc_pkg::*;

    localparam int LATENCY = 10;
    localparam int WATCHDOG = 20000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    int           errors, pending, blocks_seen, loads_seen;
    int           idle_cycles = 0;

    always #2 clk = ~clk;

    aes128_encrypt_block_unit dut (.*);

    aes128_encrypt_checker chk (.*);

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    logic stall_phase = 1'b0;
    int   rx_wait = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_wait > 0)
            begin
                rx_wait  <= rx_wait - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 199) == 0)
                    stall_phase <= ~stall_phase;
                m_tready <= 1'b1;
                if (stall_phase && $urandom_range(0, 3) == 0)
                    rx_wait <= gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("aes128_encrypt_block_unit: mismatch");
            $finish;
        end
    end

    bit send_gaps = 1'b1;

    task automatic send_word(op_t op, logic [3:0] idx, logic [63:0] hi, logic [63:0] lo);
        int g;
        g = send_gaps ? gap_len() : 0;
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'h0, lo, hi, idx};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic load_random_keys();
        for (int i = 0; i < NUM_KEYS; i++)
            send_word(OP_LOAD_KEY, i[3:0], {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    // FIPS-197 appendix C.1 expanded key
    logic [127:0] fips_keys [NUM_KEYS] = '{
        128'h000102030405060708090a0b0c0d0e0f, 128'hd6aa74fdd2af72fadaa678f1d6ab76fe,
        128'hb692cf0b643dbdf1be9bc5006830b3fe, 128'hb6ff744ed2c2c9bf6c590cbf0469bf41,
        128'h47f7f7bc95353e03f96c32bcfd058dfd, 128'h3caaa3e8a99f9deb50f3af57adf622aa,
        128'h5e390f7df7a69296a7553dc10aa31f6b, 128'h14f9701ae35fe28c440adf4d4ea9c026,
        128'h47438735a41c65b9e016baf4aebf7ad2, 128'h549932d1f08557681093ed9cbe2c974e,
        128'h13111d7fe3944a17f307a78b4d2b30c5};

    initial
    begin
        logic [63:0] hi, lo;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_KEYS; i++)
            send_word(OP_LOAD_KEY, i[3:0], fips_keys[i][127:64], fips_keys[i][63:0]);
        // out of range slots must be ignored
        for (int i = NUM_KEYS; i < 16; i++)
            send_word(OP_LOAD_KEY, i[3:0], '1, '1);
        send_word(OP_ENCRYPT, 4'h0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_word(OP_ENCRYPT, 4'hf, '0, '0);
        send_word(OP_ENCRYPT, 4'h5, '1, '1);
        send_word(OP_ENCRYPT, 4'h0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        drain();

        load_random_keys();
        send_word(OP_ENCRYPT, 4'h0, '0, '1);
        send_word(OP_ENCRYPT, 4'ha, '1, '0);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            send_gaps = (phase % 3) != 2;
            if (phase > 0)
            begin
                if ($urandom_range(0, 1))
                    load_random_keys();
                else
                    send_word(OP_LOAD_KEY, 4'($urandom_range(0, 15)),
                              {$urandom, $urandom}, {$urandom, $urandom});
            end
            for (int n = 0; n < 80; n++)
            begin
                hi = {$urandom, $urandom};
                lo = {$urandom, $urandom};
                send_word(OP_ENCRYPT, 4'($urandom_range(0, 15)), hi, lo);
            end
            drain();
        end

        s_tvalid <= 1'b0;
        repeat (LATENCY + 4) @(posedge clk);
        $display("covered %0d encrypted blocks and %0d key loads, out of range slots included",
                 blocks_seen, loads_seen);
        if (errors == 0 && pending == 0)
            $display("aes128_encrypt_block_unit: match");
        else
            $display("aes128_encrypt_block_unit: mismatch");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/aesenc_pkg.sv
rtl/core/aesenc_round.sv
rtl/core/aes128_encrypt_block_unit.sv
rtl/core/aesenc_checker.sv
tb/aes128_encrypt_checker.sv
tb/tb_aes128_encrypt_block_unit.sv
